// File: rtl/core/text_cursor_layout_bounds_defines.svh
// Assertion macros shared by the text cursor layout RTL.
// Each macro takes a label, an antecedent, a consequent and a message.
`ifndef TEXT_CURSOR_LAYOUT_BOUNDS_DEFINES_SVH
`define TEXT_CURSOR_LAYOUT_BOUNDS_DEFINES_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent.
`define TCLB_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TCLB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define TCLB_ASSERT_SAME(label, ante, cons, msg)
`define TCLB_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// File: rtl/core/tclb_pkg.sv
package tclb_pkg;

   // Character codes with special handling.
   localparam logic [7:0] CODE_LF = 8'd10;
   localparam logic [7:0] CODE_CR = 8'd13;

   // Configuration register indexes.
   localparam logic [1:0] CSR_TEXT_SIZE  = 2'd0;
   localparam logic [1:0] CSR_LINE_WIDTH = 2'd1;

   // Reset values.
   localparam logic [7:0]  TEXT_SIZE_RESET  = 8'd1;
   localparam logic [11:0] LINE_WIDTH_RESET = 12'd240;
   localparam logic [15:0] LEAST_RESET      = 16'h7FFF;
   localparam logic [15:0] MOST_RESET       = 16'hFFFF;

   // One input item.
   typedef struct packed {
      logic [7:0]         char_code;
      logic               first;
      logic signed [15:0] start_x;
      logic signed [15:0] start_y;
   } req_type;

   // One result item.
   typedef struct packed {
      logic               placed;
      logic signed [15:0] glyph_x;
      logic signed [15:0] glyph_y;
      logic signed [15:0] bound_x;
      logic signed [15:0] bound_y;
      logic [15:0]        bound_w;
      logic [15:0]        bound_h;
   } rsp_type;

   // Configuration registers.
   typedef struct packed {
      logic [7:0]  text_size;
      logic [11:0] line_width;
   } cfg_type;

   // Cursor, origin and running box extremes.
   typedef struct packed {
      logic [15:0] cursor_x;
      logic [15:0] cursor_y;
      logic [15:0] origin_x;
      logic [15:0] origin_y;
      logic [15:0] least_x;
      logic [15:0] least_y;
      logic [15:0] most_x;
      logic [15:0] most_y;
   } layout_state_type;

endpackage

// File: rtl/core/text_cursor_layout_bounds.sv
// Channel   Direction  Handshake              Payload
// req       in         req_valid, req_stall   req_item  (tclb_pkg::req_type)
// rsp       out        rsp_valid, rsp_stall   rsp_item  (tclb_pkg::rsp_type)
// csr       in         csr_valid, csr_ready   csr_index, csr_data
//
// One item is accepted per cycle while req_stall is low; its result passes from
// the input register through the step logic, which does the cursor update, into
// the result register, from which it leaves.
// Synchronous reset empties both stages, clears the cursor and origin, empties
// the box and loads text size 1 and line width 240. csr_ready is always high.
// A stalled result holds; req_stall rises only when both stages are full.
`include "text_cursor_layout_bounds_defines.svh"

module text_cursor_layout_bounds
   import tclb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_item,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_item,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [11:0] csr_data
);

   logic             in_vld_ff;
   req_type          in_item_ff;
   logic             out_vld_ff;
   logic             out_vld_in;
   rsp_type          out_item_ff;
   cfg_type          cfg_ff;
   cfg_type          cfg_in;
   layout_state_type state_ff;
   layout_state_type state_in;
   layout_state_type state_step;
   rsp_type          step_result;
   logic             out_load;
   logic             in_load;

   // The result register takes a new item when empty or being drained.
   assign out_load  = in_vld_ff && (!out_vld_ff || !rsp_stall);
   assign req_stall = in_vld_ff && !out_load;
   assign in_load   = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   tclb_step u_step (
      .item      (in_item_ff),
      .cfg       (cfg_ff),
      .state_cur (state_ff),
      .state_nxt (state_step),
      .result    (step_result)
   );

   // Configuration writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_TEXT_SIZE:  cfg_in.text_size  = csr_data[7:0];
            CSR_LINE_WIDTH: cfg_in.line_width = csr_data;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   // Cursor state follows every item that enters the result register.
   assign state_in   = out_load ? state_step : state_ff;
   assign out_vld_in = out_load || (out_vld_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff         <= 1'b0;
         out_vld_ff        <= 1'b0;
         cfg_ff.text_size  <= TEXT_SIZE_RESET;
         cfg_ff.line_width <= LINE_WIDTH_RESET;
         state_ff.cursor_x <= '0;
         state_ff.cursor_y <= '0;
         state_ff.origin_x <= '0;
         state_ff.origin_y <= '0;
         state_ff.least_x  <= LEAST_RESET;
         state_ff.least_y  <= LEAST_RESET;
         state_ff.most_x   <= MOST_RESET;
         state_ff.most_y   <= MOST_RESET;
      end else begin
         cfg_ff     <= cfg_in;
         state_ff   <= state_in;
         out_vld_ff <= out_vld_in;
         if (in_load) begin
            in_vld_ff <= 1'b1;
         end else if (out_load) begin
            in_vld_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (in_load) begin
         in_item_ff <= req_item;
      end
      if (out_load) begin
         out_item_ff <= step_result;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_item  = out_item_ff;

   `TCLB_ASSERT_NEXT(a_accept_fills_input, in_load, in_vld_ff, "accepted item did not reach the input register")
   `TCLB_ASSERT_NEXT(a_load_fills_output, out_load, out_vld_ff, "step result did not reach the result register")
   `TCLB_ASSERT_SAME(a_unplaced_zero, out_vld_ff && !out_item_ff.placed, out_item_ff.glyph_x == 16'sd0 && out_item_ff.glyph_y == 16'sd0, "unplaced item carries a glyph position")
   `TCLB_ASSERT_NEXT(a_first_sets_origin, out_load && in_item_ff.first, state_ff.origin_x == $past(in_item_ff.start_x) && state_ff.origin_y == $past(in_item_ff.start_y), "first item did not load the origin")

endmodule

// File: rtl/core/tclb_step.sv
module tclb_step
   import tclb_pkg::*;
(
   input  req_type          item,
   input  cfg_type          cfg,
   input  layout_state_type state_cur,
   output layout_state_type state_nxt,
   output rsp_type          result
);

   logic [15:0]        cell_w;
   logic [15:0]        cell_h;
   logic               is_lf;
   logic               is_cr;
   logic signed [17:0] wrap_sum;
   logic signed [17:0] wrap_limit;
   logic               wrap;
   logic [15:0]        gx;
   logic [15:0]        gy;
   logic [15:0]        ex;
   logic [15:0]        ey;
   layout_state_type   base;
   layout_state_type   upd;

   // Cell size is 6 and 8 times the text size, built from shifts.
   assign cell_w = {6'd0, cfg.text_size, 2'b00} + {7'd0, cfg.text_size, 1'b0};
   assign cell_h = {5'd0, cfg.text_size, 3'b000};

   assign is_lf = (item.char_code == CODE_LF);
   assign is_cr = (item.char_code == CODE_CR);

   // A first item reloads the cursor and origin and empties the box.
   always_comb begin
      base = state_cur;
      if (item.first) begin
         base.cursor_x = item.start_x;
         base.cursor_y = item.start_y;
         base.origin_x = item.start_x;
         base.origin_y = item.start_y;
         base.least_x  = LEAST_RESET;
         base.least_y  = LEAST_RESET;
         base.most_x   = MOST_RESET;
         base.most_y   = MOST_RESET;
      end
   end

   // The wrap test runs at full precision, with no 16-bit wrap.
   assign wrap_sum   = $signed({{2{base.cursor_x[15]}}, base.cursor_x})
                     + $signed({2'b00, cell_w});
   assign wrap_limit = $signed({6'd0, cfg.line_width});
   assign wrap       = (wrap_sum > wrap_limit);

   assign gx = wrap ? 16'd0 : base.cursor_x;
   assign gy = wrap ? (base.cursor_y + cell_h) : base.cursor_y;
   assign ex = gx + cell_w - 16'd1;
   assign ey = gy + cell_h - 16'd1;

   // Cursor movement and box growth for the three kinds of code, then the
   // box report, or the origin with zero size where it is empty.
   always_comb begin
      upd            = base;
      result.placed  = 1'b0;
      result.glyph_x = '0;
      result.glyph_y = '0;
      if (is_lf) begin
         upd.cursor_x = '0;
         upd.cursor_y = base.cursor_y + cell_h;
      end else if (!is_cr) begin
         result.placed  = 1'b1;
         result.glyph_x = gx;
         result.glyph_y = gy;
         upd.cursor_x   = gx + cell_w;
         upd.cursor_y   = gy;
         if ($signed(ex) > $signed(base.most_x)) begin
            upd.most_x = ex;
         end
         if ($signed(ey) > $signed(base.most_y)) begin
            upd.most_y = ey;
         end
         if ($signed(gx) < $signed(base.least_x)) begin
            upd.least_x = gx;
         end
         if ($signed(gy) < $signed(base.least_y)) begin
            upd.least_y = gy;
         end
      end
      if ($signed(upd.most_x) >= $signed(upd.least_x)) begin
         result.bound_x = upd.least_x;
         result.bound_w = upd.most_x - upd.least_x + 16'd1;
      end else begin
         result.bound_x = upd.origin_x;
         result.bound_w = '0;
      end
      if ($signed(upd.most_y) >= $signed(upd.least_y)) begin
         result.bound_y = upd.least_y;
         result.bound_h = upd.most_y - upd.least_y + 16'd1;
      end else begin
         result.bound_y = upd.origin_y;
         result.bound_h = '0;
      end
   end

   assign state_nxt = upd;

endmodule

// File: dv/tb_text_cursor_layout_bounds.sv
module tb_text_cursor_layout_bounds
   import tclb_pkg::*;
();

   // Register index that maps to no register; writes to it must be ignored.
   localparam logic [1:0] CSR_SPARE = 2'd3;
   localparam int PHASES = 12;
   localparam int CHARS_PER_PHASE = 111;

   // One row of the directed table: the item and, where fixed is set, its result.
   typedef struct packed {
      req_type item;
      logic    fixed;
      rsp_type want;
   } script_row_type;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   req_type     req_item  = '0;
   logic        rsp_stall = 1'b0;
   logic        csr_valid = 1'b0;
   logic [1:0]  csr_index = CSR_TEXT_SIZE;
   logic [11:0] csr_data  = '0;
   wire         req_stall;
   wire         rsp_valid;
   rsp_type     rsp_item;
   wire         csr_ready;

   // Model of the layout state and its configuration.
   logic [7:0]  size_reg;
   logic [11:0] width_reg;
   logic [15:0] cur_x, cur_y, org_x, org_y;
   logic [15:0] lo_x, lo_y, hi_x, hi_y;

   rsp_type        pending_layouts[$];
   script_row_type script_rows[$];
   rsp_type        oldest;
   int             mismatches = 0;
   int             stall_left = 0;
   int             run_left = 0;
   bit             no_gaps = 1'b0;

   text_cursor_layout_bounds u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #6 clock = ~clock;

   // Lays out one character and returns the glyph cell and the running box.
   function automatic rsp_type layout_step(input req_type it);
      rsp_type     r;
      logic [15:0] cw, ch, ex, ey;
      int          sx;
      r  = '0;
      cw = 16'(6 * int'(size_reg));
      ch = 16'(8 * int'(size_reg));
      if (it.first) begin
         cur_x = it.start_x;
         cur_y = it.start_y;
         org_x = cur_x;
         org_y = cur_y;
         lo_x  = LEAST_RESET;
         lo_y  = LEAST_RESET;
         hi_x  = MOST_RESET;
         hi_y  = MOST_RESET;
      end
      if (it.char_code == CODE_LF) begin
         cur_x = '0;
         cur_y = cur_y + ch;
      end else if (it.char_code != CODE_CR) begin
         // The wrap test is done at full precision, without 16-bit wrap.
         sx = int'($signed(cur_x));
         if (sx + int'(cw) > int'(width_reg)) begin
            cur_x = '0;
            cur_y = cur_y + ch;
         end
         r.placed  = 1'b1;
         r.glyph_x = cur_x;
         r.glyph_y = cur_y;
         ex = cur_x + cw - 16'd1;
         ey = cur_y + ch - 16'd1;
         if ($signed(ex) > $signed(hi_x)) hi_x = ex;
         if ($signed(ey) > $signed(hi_y)) hi_y = ey;
         if ($signed(cur_x) < $signed(lo_x)) lo_x = cur_x;
         if ($signed(cur_y) < $signed(lo_y)) lo_y = cur_y;
         cur_x = cur_x + cw;
      end
      // An axis with no extent reports the origin and a size of zero.
      if ($signed(hi_x) >= $signed(lo_x)) begin
         r.bound_x = lo_x;
         r.bound_w = hi_x - lo_x + 16'd1;
      end else begin
         r.bound_x = org_x;
         r.bound_w = '0;
      end
      if ($signed(hi_y) >= $signed(lo_y)) begin
         r.bound_y = lo_y;
         r.bound_h = hi_y - lo_y + 16'd1;
      end else begin
         r.bound_y = org_y;
         r.bound_h = '0;
      end
      return r;
   endfunction

   // A coordinate near the origin, near either end of the 16-bit range, or anywhere.
   function automatic logic [15:0] pick_coord(input int span);
      case ($urandom_range(0, 7))
         0, 1, 2: return 16'($urandom);
         3, 4:    return 16'($urandom_range(0, span));
         5:       return 16'h7FFF - 16'($urandom_range(0, 40));
         6:       return 16'h8000 + 16'($urandom_range(0, 40));
         default: return 16'hFFFF - 16'($urandom_range(0, 40));
      endcase
   endfunction

   // Mostly strings that open with a first item, with some noise mixed in.
   function automatic req_type random_char();
      req_type it;
      int      roll;
      it.start_x = pick_coord(int'(width_reg) + 10);
      it.start_y = pick_coord(300);
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
         it.first     = 1'($urandom_range(0, 1));
         it.char_code = 8'($urandom_range(0, 255));
      end else begin
         if (run_left == 0) begin
            it.first = 1'b1;
            run_left = $urandom_range(2, 30);
         end else begin
            it.first = 1'b0;
         end
         run_left--;
         roll = $urandom_range(0, 99);
         if (roll < 80)      it.char_code = 8'($urandom_range(32, 126));
         else if (roll < 92) it.char_code = CODE_LF;
         else if (roll < 97) it.char_code = CODE_CR;
         else                it.char_code = 8'($urandom_range(0, 255));
      end
      return it;
   endfunction

   task automatic add_row(input req_type it, input logic fixed, input rsp_type want);
      script_rows.push_back('{it, fixed, want});
   endtask

   // Offers one item after a random gap, unless no_gaps is set, and records its result once it is taken.
   task automatic send_char(input req_type it, input logic fixed, input rsp_type want);
      int      gap;
      rsp_type predicted;
      gap = no_gaps ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= it;
      do @(posedge clock); while (req_stall);
      predicted = layout_step(it);
      pending_layouts.push_back(fixed ? want : predicted);
   endtask

   // Holds the sender off until every result is back and the pipeline is empty.
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_layouts.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Writes both registers back to back, and optionally the unmapped index.
   task automatic apply_config(input logic [7:0] size, input logic [11:0] width,
                               input bit poke_spare);
      csr_valid <= 1'b1;
      csr_index <= CSR_TEXT_SIZE;
      csr_data  <= {4'($urandom), size};
      do @(posedge clock); while (!csr_ready);
      size_reg = size;
      csr_index <= CSR_LINE_WIDTH;
      csr_data  <= width;
      do @(posedge clock); while (!csr_ready);
      width_reg = width;
      if (poke_spare) begin
         csr_index <= CSR_SPARE;
         csr_data  <= 12'($urandom);
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
   endtask

   task automatic check_field(input string field, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %h got %h", $time, field, want, got);
         mismatches++;
      end
   endtask

   // Result side: compare each item taken with the oldest expectation, then draw a stall.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_layouts.size() == 0) begin
               $display("%0t: result %h arrived with nothing expected", $time, rsp_item);
               mismatches++;
            end else begin
               oldest = pending_layouts.pop_front();
               check_field("placed", 16'(oldest.placed), 16'(rsp_item.placed));
               check_field("glyph_x", oldest.glyph_x, rsp_item.glyph_x);
               check_field("glyph_y", oldest.glyph_y, rsp_item.glyph_y);
               check_field("bound_x", oldest.bound_x, rsp_item.bound_x);
               check_field("bound_y", oldest.bound_y, rsp_item.bound_y);
               check_field("bound_w", oldest.bound_w, rsp_item.bound_w);
               check_field("bound_h", oldest.bound_h, rsp_item.bound_h);
            end
            stall_left = no_gaps ? 0 : $urandom_range(0, 17);
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Main sequence: directed table, then phases of random strings under varied settings.
   initial begin
      logic [7:0]  size;
      logic [11:0] width;
      size_reg  = TEXT_SIZE_RESET;
      width_reg = LINE_WIDTH_RESET;
      cur_x = '0;
      cur_y = '0;
      org_x = '0;
      org_y = '0;
      lo_x  = LEAST_RESET;
      lo_y  = LEAST_RESET;
      hi_x  = MOST_RESET;
      hi_y  = MOST_RESET;

      // Straight after reset the box is empty and the origin is zero.
      add_row(req_type'{CODE_CR, 1'b0, 16'sd0, 16'sd0}, 1'b1,
              rsp_type'{1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd0, 16'd0});
      add_row(req_type'{CODE_LF, 1'b0, 16'sd0, 16'sd0}, 1'b1,
              rsp_type'{1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd0, 16'd0});
      add_row(req_type'{8'h41, 1'b1, 16'sd0, 16'sd0}, 1'b1,
              rsp_type'{1'b1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd6, 16'd8});
      // Code zero and the top code are ordinary characters.
      add_row(req_type'{8'h00, 1'b0, 16'sd0, 16'sd0}, 1'b0, '0);
      add_row(req_type'{8'hFF, 1'b0, 16'h7FFF, 16'h8000}, 1'b0, '0);
      add_row(req_type'{CODE_LF, 1'b0, 16'sd0, 16'sd0}, 1'b0, '0);
      add_row(req_type'{CODE_CR, 1'b0, 16'sd0, 16'sd0}, 1'b0, '0);
      // A cell that just fits, then one that wraps.
      add_row(req_type'{8'h42, 1'b1, 16'sd234, 16'sd0}, 1'b0, '0);
      add_row(req_type'{8'h43, 1'b0, 16'sd0, 16'sd0}, 1'b0, '0);
      add_row(req_type'{8'h44, 1'b1, 16'sd240, 16'sd0}, 1'b1,
              rsp_type'{1'b1, 16'sd0, 16'sd8, 16'sd0, 16'sd8, 16'd6, 16'd8});
      // Start points at the extremes of the coordinate range.
      add_row(req_type'{8'h58, 1'b1, 16'h7FFF, 16'h7FFF}, 1'b0, '0);
      add_row(req_type'{8'h59, 1'b1, 16'h8000, 16'h8000}, 1'b0, '0);
      add_row(req_type'{8'h7E, 1'b0, 16'hFFFF, 16'h5555}, 1'b0, '0);
      add_row(req_type'{8'h5A, 1'b1, 16'sd0, 16'sd32765}, 1'b0, '0);
      add_row(req_type'{8'h61, 1'b1, -16'sd5, -16'sd3}, 1'b0, '0);
      add_row(req_type'{8'h7F, 1'b0, 16'h0000, 16'hFFFF}, 1'b0, '0);
      add_row(req_type'{8'h80, 1'b0, 16'hAAAA, 16'h0000}, 1'b0, '0);
      // A first item that places nothing leaves an empty box at its start point.
      add_row(req_type'{CODE_LF, 1'b1, 16'sd100, 16'sd200}, 1'b1,
              rsp_type'{1'b0, 16'sd0, 16'sd0, 16'sd100, 16'sd200, 16'd0, 16'd0});
      add_row(req_type'{CODE_CR, 1'b1, -16'sd1, -16'sd1}, 1'b1,
              rsp_type'{1'b0, 16'sd0, 16'sd0, -16'sd1, -16'sd1, 16'd0, 16'd0});
      add_row(req_type'{8'hFF, 1'b1, 16'sd0, 16'sd0}, 1'b1,
              rsp_type'{1'b1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd6, 16'd8});

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int p = 0; p < PHASES; p++) begin
         if (p > 0) begin
            settle();
            case (p)
               1:       begin size = 8'd255; width = 12'd4095; end
               2:       begin size = 8'd1;   width = 12'd1;    end
               3:       begin size = 8'd0;   width = 12'd240;  end
               4:       begin size = 8'd255; width = 12'd0;    end
               5:       begin size = 8'd2;   width = 12'd4095; end
               6:       begin size = 8'd1;   width = 12'd0;    end
               default: begin
                  size  = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                      : 8'($urandom_range(1, 4));
                  width = 12'($urandom);
               end
            endcase
            apply_config(size, width, p == 1);
         end
         no_gaps = (p == 3 || p == 8);
         if (p == 0) begin
            foreach (script_rows[r]) begin
               send_char(script_rows[r].item, script_rows[r].fixed, script_rows[r].want);
            end
         end
         for (int i = 0; i < CHARS_PER_PHASE; i++) begin
            // Midway through one phase the sender waits for every result.
            if (p == 5 && i == CHARS_PER_PHASE / 2) settle();
            send_char(random_char(), 1'b0, '0);
         end
      end

      settle();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && pending_layouts.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #7000000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/tclb_pkg.sv
rtl/core/tclb_step.sv
rtl/core/text_cursor_layout_bounds.sv
dv/tb_text_cursor_layout_bounds.sv
